// ===== rtl/dtcd_pkg.sv =====
// ----------------------------------------------------------------------------
// dtcd_pkg
// Shared constants and types for the deadband threshold change detector:
// result codes, opcodes, register indexes and the configuration record.
// ----------------------------------------------------------------------------
package dtcd_pkg;

    // default sample width, signed q16.16
    localparam int SAMPLE_WIDTH_DEF = 32;

    // fixed field widths
    localparam int LIMIT_W     = 32;
    localparam int DEAD_BAND_W = 31;
    localparam int SEV_W       = 3;
    localparam int TIME_W      = 32;
    localparam int CODE_W      = 2;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LIMIT        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LIMIT_ENABLE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_LIMIT         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_LIMIT_ENABLE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_BAND         = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SEVERITY_LEVEL    = 3'd5;

    // request opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // result codes
    localparam logic [CODE_W-1:0] CODE_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_MEAS   = 2'd1;
    localparam logic [CODE_W-1:0] CODE_HEALTH = 2'd2;

    // configuration record
    typedef struct packed {
        logic [LIMIT_W-1:0]     high_limit;
        logic                   high_limit_enable;
        logic [LIMIT_W-1:0]     low_limit;
        logic                   low_limit_enable;
        logic [DEAD_BAND_W-1:0] dead_band;
        logic [SEV_W-1:0]       severity_level;
    } cfg_t;

    // store update controls from the evaluation logic
    typedef struct packed {
        logic store;
        logic clear;
    } upd_t;

endpackage

// ===== rtl/dtcd_if.sv =====
// ----------------------------------------------------------------------------
// dtcd interfaces
// Valid/ready channels for sample requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface dtcd_in_if #(
    parameter int SAMPLE_WIDTH = dtcd_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic                           read_ok;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [dtcd_pkg::TIME_W-1:0]    now_ms;

    modport source (output valid, output opcode, output read_ok, output sample,
                    output now_ms, input ready);
    modport sink   (input valid, input opcode, input read_ok, input sample,
                    input now_ms, output ready);
endinterface

interface dtcd_out_if #(
    parameter int SAMPLE_WIDTH = dtcd_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic [dtcd_pkg::CODE_W-1:0]    result_code;
    logic                           above_limit;
    logic signed [SAMPLE_WIDTH:0]   change;
    logic signed [SAMPLE_WIDTH-1:0] sample_echo;
    logic [dtcd_pkg::SEV_W-1:0]     severity_out;

    modport source (output valid, output result_code, output above_limit,
                    output change, output sample_echo, output severity_out,
                    input ready);
    modport sink   (input valid, input result_code, input above_limit,
                    input change, input sample_echo, input severity_out,
                    output ready);
endinterface

interface dtcd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dtcd_pkg::CFG_ADDR_W-1:0] index;
    logic [dtcd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/dtcd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dtcd_cfg_regs
// Configuration register file: limits, limit enables, deadband and severity.
// ----------------------------------------------------------------------------
module dtcd_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    dtcd_cfg_if.sink         cfg,
    output dtcd_pkg::cfg_t   cfg_regs
);

    dtcd_pkg::cfg_t cfg_reg;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dtcd_pkg::REG_HIGH_LIMIT:
                    cfg_reg.high_limit <= cfg.data[dtcd_pkg::LIMIT_W-1:0];
                dtcd_pkg::REG_HIGH_LIMIT_ENABLE:
                    cfg_reg.high_limit_enable <= cfg.data[0];
                dtcd_pkg::REG_LOW_LIMIT:
                    cfg_reg.low_limit <= cfg.data[dtcd_pkg::LIMIT_W-1:0];
                dtcd_pkg::REG_LOW_LIMIT_ENABLE:
                    cfg_reg.low_limit_enable <= cfg.data[0];
                dtcd_pkg::REG_DEAD_BAND:
                    cfg_reg.dead_band <= cfg.data[dtcd_pkg::DEAD_BAND_W-1:0];
                dtcd_pkg::REG_SEVERITY_LEVEL:
                    cfg_reg.severity_level <= cfg.data[dtcd_pkg::SEV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/dtcd_eval.sv =====
// ----------------------------------------------------------------------------
// dtcd_eval
// Evaluation of one sample request against the limits and the stored reading.
// ----------------------------------------------------------------------------
module dtcd_eval #(
    parameter int SAMPLE_WIDTH = dtcd_pkg::SAMPLE_WIDTH_DEF
) (
    input  dtcd_pkg::cfg_t                cfg_regs,
    input  logic                          opcode,
    input  logic                          read_ok,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                          present,
    input  logic signed [SAMPLE_WIDTH-1:0] stored,
    output logic [dtcd_pkg::CODE_W-1:0]   result_code,
    output logic                          above_limit,
    output logic signed [SAMPLE_WIDTH:0]  change,
    output dtcd_pkg::upd_t                upd
);

    localparam int CHANGE_W = SAMPLE_WIDTH + 1;
    localparam int MAG_W    = (CHANGE_W > dtcd_pkg::DEAD_BAND_W) ?
                              CHANGE_W : dtcd_pkg::DEAD_BAND_W;

    logic signed [CHANGE_W-1:0] diff;
    logic [CHANGE_W-1:0]        mag;
    logic [MAG_W-1:0]           mag_ext;
    logic [MAG_W-1:0]           band_ext;
    logic                       hit_high;
    logic                       hit_low;
    logic                       below_band;

    // exact difference against the stored reading
    always_comb
    begin
        diff = CHANGE_W'(sample) - CHANGE_W'(stored);
        if (!present)
        begin
            diff = '0;
        end
    end

    // magnitude against the deadband
    assign mag        = diff[CHANGE_W-1] ? CHANGE_W'(-diff) : CHANGE_W'(diff);
    assign mag_ext    = MAG_W'(mag);
    assign band_ext   = MAG_W'(cfg_regs.dead_band);
    assign below_band = (cfg_regs.dead_band != '0) && (mag_ext < band_ext);

    // limit checks, both sides sign extended by the compare
    assign hit_high = cfg_regs.high_limit_enable &&
                      (sample >= $signed(cfg_regs.high_limit));
    assign hit_low  = cfg_regs.low_limit_enable &&
                      (sample <= $signed(cfg_regs.low_limit));

    // decision, upper limit wins over lower
    always_comb
    begin
        result_code = dtcd_pkg::CODE_NONE;
        above_limit = 1'b0;
        change      = diff;
        upd         = '0;
        if (opcode == dtcd_pkg::OP_CLEAR)
        begin
            change    = '0;
            upd.clear = 1'b1;
        end
        else if (!read_ok)
        begin
            change = '0;
        end
        else if (hit_high)
        begin
            result_code = dtcd_pkg::CODE_HEALTH;
            above_limit = 1'b1;
            upd.store   = 1'b1;
        end
        else if (hit_low)
        begin
            result_code = dtcd_pkg::CODE_HEALTH;
            upd.store   = 1'b1;
        end
        else if (!present || !below_band)
        begin
            result_code = dtcd_pkg::CODE_MEAS;
            upd.store   = 1'b1;
        end
    end

endmodule

// ===== rtl/deadband_threshold_change_detector.sv =====
// ----------------------------------------------------------------------------
// deadband_threshold_change_detector
// Single channel report-by-exception detector with alarm limits and deadband.
// ----------------------------------------------------------------------------
// usage
//   in_ch  : sample requests (opcode, read_ok, sample, now_ms), valid/ready
//   out_ch : one result per request (code, above_limit, change, echo,
//            severity), valid/ready
//   cfg    : register writes (index, data), always ready; write only while
//            no request is in flight
// timing
//   a request taken at one edge sits in the input register, is evaluated
//   and lands in the result register at the next edge: the result is valid
//   one cycle after acceptance. one request per cycle is sustained; the
//   stored reading is updated in the same cycle a request is evaluated, so
//   the next request sees it straight away.
// reset
//   configuration clears to zero (limits off, deadband off), store empty
// stall
//   while out_ch is stalled the result holds; one more request is taken into
//   the input register, after which in_ch.ready drops until the result goes
// ----------------------------------------------------------------------------
module deadband_threshold_change_detector #(
    parameter int SAMPLE_WIDTH = dtcd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dtcd_in_if.sink   in_ch,
    dtcd_out_if.source out_ch,
    dtcd_cfg_if.sink  cfg
);

    dtcd_pkg::cfg_t cfg_regs;

    // input register
    logic                           s1_valid_reg;
    logic                           s1_opcode_reg;
    logic                           s1_read_ok_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample_reg;
    logic [dtcd_pkg::TIME_W-1:0]    s1_now_reg;

    // result register
    logic                           res_valid_reg;
    logic [dtcd_pkg::CODE_W-1:0]    res_code_reg;
    logic                           res_above_reg;
    logic signed [SAMPLE_WIDTH:0]   res_change_reg;
    logic signed [SAMPLE_WIDTH-1:0] res_echo_reg;
    logic [dtcd_pkg::SEV_W-1:0]     res_sev_reg;

    // stored reading
    logic                           present_reg;
    logic signed [SAMPLE_WIDTH-1:0] stored_reg;
    logic [dtcd_pkg::TIME_W-1:0]    event_time_reg;

    // evaluation outputs
    logic [dtcd_pkg::CODE_W-1:0]    ev_code;
    logic                           ev_above;
    logic signed [SAMPLE_WIDTH:0]   ev_change;
    dtcd_pkg::upd_t                 ev_upd;

    logic res_free;
    logic advance;
    logic take;

    dtcd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    dtcd_eval #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_eval (
        .cfg_regs    (cfg_regs),
        .opcode      (s1_opcode_reg),
        .read_ok     (s1_read_ok_reg),
        .sample      (s1_sample_reg),
        .present     (present_reg),
        .stored      (stored_reg),
        .result_code (ev_code),
        .above_limit (ev_above),
        .change      (ev_change),
        .upd         (ev_upd)
    );

    // pipeline flow
    assign res_free    = !res_valid_reg || out_ch.ready;
    assign advance     = s1_valid_reg && res_free;
    assign in_ch.ready = !s1_valid_reg || res_free;
    assign take        = in_ch.valid && in_ch.ready;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (res_free)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    // input payload capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_opcode_reg  <= in_ch.opcode;
            s1_read_ok_reg <= in_ch.read_ok;
            s1_sample_reg  <= in_ch.sample;
            s1_now_reg     <= in_ch.now_ms;
        end
    end

    // result payload capture
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_code_reg   <= ev_code;
            res_above_reg  <= ev_above;
            res_change_reg <= ev_change;
            res_echo_reg   <= s1_sample_reg;
            res_sev_reg    <= cfg_regs.severity_level;
        end
    end

    // store update as each request is evaluated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= 1'b0;
            stored_reg     <= '0;
            event_time_reg <= '0;
        end
        else if (advance)
        begin
            if (ev_upd.clear)
            begin
                present_reg    <= 1'b0;
                stored_reg     <= '0;
                event_time_reg <= '0;
            end
            else if (ev_upd.store)
            begin
                present_reg    <= 1'b1;
                stored_reg     <= s1_sample_reg;
                event_time_reg <= s1_now_reg;
            end
        end
    end

    // result channel
    assign out_ch.valid        = res_valid_reg;
    assign out_ch.result_code  = res_code_reg;
    assign out_ch.above_limit  = res_above_reg;
    assign out_ch.change       = res_change_reg;
    assign out_ch.sample_echo  = res_echo_reg;
    assign out_ch.severity_out = res_sev_reg;

endmodule
